/* hdl/id3p_pkg.sv */
package id3p_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [2:0] tag_version;
    logic [1:0] field_id;
    logic [1:0] text_encoding;
    logic [7:0] text_byte;
    logic       last_of_frame;
  } out_item_t;

  localparam logic [2:0] EV_HDR_OK  = 3'd0;
  localparam logic [2:0] EV_HDR_BAD = 3'd1;
  localparam logic [2:0] EV_TEXT    = 3'd2;
  localparam logic [2:0] EV_TAG_END = 3'd3;
  localparam logic [2:0] EV_BAD_ENC = 3'd4;
  localparam logic [2:0] EV_NO_DLI  = 3'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam logic [3:0] MASK_RESET = 4'hF;
  localparam logic [27:0] COUNT_MAX = 28'hFFFFFFF;

endpackage

/* hdl/id3p_front.sv */
module id3p_front (
  input  logic                 in_push,
  output logic                 in_full,
  input  id3p_pkg::in_item_t   in_item,
  output logic                 q_push,
  input  logic                 q_full,
  output id3p_pkg::in_item_t   q_item
);

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;
  assign q_item  = in_item;

endmodule

/* hdl/id3p_queue.sv */
module id3p_queue #(
  parameter int DEPTH = id3p_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  id3p_pkg::in_item_t  wr_data,
  output logic                full,
  input  logic                rd_en,
  output logic                empty,
  output id3p_pkg::in_item_t  rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  id3p_pkg::in_item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

/* hdl/id3p_back.sv */
module id3p_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  id3p_pkg::in_item_t   q_item,
  output logic                 q_pop,
  input  logic [3:0]           mask,
  output logic                 out_empty,
  input  logic                 out_pop,
  output id3p_pkg::out_item_t  out_item
);

  typedef enum logic [3:0] {
    PH_HDR, PH_EXT_SIZE, PH_EXT_SKIP, PH_FHDR, PH_DLI, PH_ENC, PH_TEXT, PH_SKIP, PH_DONE
  } phase_t;

  phase_t      ph_r, ph_nxt;
  logic [7:0]  hb_r [10];
  logic [2:0]  mv_r, mv_nxt;
  logic [27:0] tsz_r, tsz_nxt;
  logic [27:0] bc_r, bc_nxt;
  logic [31:0] fid_r, fid_nxt;
  logic [31:0] frem_r, frem_nxt;
  logic [15:0] ffl_r, ffl_nxt;
  logic [3:0]  fc_r, fc_nxt;
  logic        pff_r, pff_nxt;
  logic [1:0]  cf_r, cf_nxt;
  logic [1:0]  ce_r, ce_nxt;

  logic        ov_r;
  id3p_pkg::out_item_t ob_r;

  logic        emit;
  logic [2:0]  ekind;
  logic [1:0]  efld, eenc;
  logic [7:0]  ebyte;
  logic        elast;
  logic        fire;
  logic [7:0]  b;
  logic [7:0]  hb_nxt [10];
  logic [3:0]  hl;
  logic        ok, zero, last, unsync, hit;
  logic [2:0]  f;
  logic [31:0] n, s4, fidn;
  logic [31:0] fr_dec;

  assign out_empty = !ov_r;
  assign out_item  = ob_r;
  assign fire      = !q_empty && (!ov_r || out_pop);
  assign q_pop     = fire;
  assign b         = q_item.data_byte;

  always_comb begin
    ph_nxt = ph_r; mv_nxt = mv_r; tsz_nxt = tsz_r; bc_nxt = bc_r; fid_nxt = fid_r;
    frem_nxt = frem_r; ffl_nxt = ffl_r; fc_nxt = fc_r; pff_nxt = pff_r; cf_nxt = cf_r;
    ce_nxt = ce_r;
    for (int i = 0; i < 10; i++) hb_nxt[i] = hb_r[i];
    emit = 1'b0; ekind = id3p_pkg::EV_HDR_OK; efld = '0; eenc = '0; ebyte = '0;
    elast = 1'b0;
    ok = 1'b0; zero = 1'b0; last = 1'b0; unsync = 1'b0; hit = 1'b0; f = 3'd4;
    n = '0; s4 = '0; fidn = '0; fr_dec = '0;
    hl = (mv_r == 3'd2) ? 4'd6 : 4'd10;
    if (q_item.start_of_file) begin
      ph_nxt = PH_HDR; mv_nxt = '0; tsz_nxt = '0; bc_nxt = '0; fid_nxt = '0; frem_nxt = '0;
      ffl_nxt = '0; fc_nxt = '0; pff_nxt = 1'b0; cf_nxt = '0; ce_nxt = '0; hl = 4'd10;
      for (int i = 0; i < 10; i++) hb_nxt[i] = '0;
    end
    fr_dec = (frem_nxt > 0) ? frem_nxt - 1 : frem_nxt;
    if (ph_nxt == PH_HDR) begin
      hb_nxt[fc_nxt] = b;
      fc_nxt = fc_nxt + 1'b1;
      if (fc_nxt == 4'd10) begin
        ok = hb_nxt[0] == 8'h49 && hb_nxt[1] == 8'h44 && hb_nxt[2] == 8'h33 &&
             hb_nxt[3] != 8'hFF && hb_nxt[4] != 8'hFF && hb_nxt[5][3:0] == 4'h0 &&
             ((hb_nxt[6] | hb_nxt[7] | hb_nxt[8] | hb_nxt[9]) & 8'h80) == 8'h00 &&
             hb_nxt[3] >= 8'd2 && hb_nxt[3] <= 8'd4;
        fc_nxt = '0; emit = 1'b1;
        if (!ok) begin
          mv_nxt = '0; ph_nxt = PH_DONE; ekind = id3p_pkg::EV_HDR_BAD;
        end else begin
          mv_nxt = hb_nxt[3][2:0];
          tsz_nxt = {hb_nxt[6][6:0], hb_nxt[7][6:0], hb_nxt[8][6:0], hb_nxt[9][6:0]};
          bc_nxt = '0; frem_nxt = '0;
          ph_nxt = (hb_nxt[5][6] && hb_nxt[3] >= 8'd3) ? PH_EXT_SIZE : PH_FHDR;
          ekind = id3p_pkg::EV_HDR_OK;
        end
      end
    end else if (ph_nxt == PH_DONE) begin
    end else if (ph_nxt == PH_FHDR && fc_nxt == '0 &&
                 ({1'b0, bc_nxt} + 29'(hl)) >= {1'b0, tsz_nxt}) begin
      ph_nxt = PH_DONE; emit = 1'b1; ekind = id3p_pkg::EV_TAG_END;
    end else begin
      if (bc_nxt != id3p_pkg::COUNT_MAX) bc_nxt = bc_nxt + 1'b1;
      case (ph_nxt)
        PH_EXT_SIZE: begin
          hb_nxt[fc_nxt] = b;
          fc_nxt = fc_nxt + 1'b1;
          if (fc_nxt >= 4'd4) begin
            if (mv_nxt == 3'd4) begin
              s4 = {4'h0, hb_nxt[0][6:0], hb_nxt[1][6:0], hb_nxt[2][6:0], hb_nxt[3][6:0]};
              n = (s4 >= 32'd4) ? s4 - 32'd4 : '0;
            end else begin
              n = {hb_nxt[0], hb_nxt[1], hb_nxt[2], hb_nxt[3]};
            end
            frem_nxt = n;
            if (n == '0) begin ph_nxt = PH_FHDR; fc_nxt = '0; end
            else ph_nxt = PH_EXT_SKIP;
          end
        end
        PH_FHDR: begin
          hb_nxt[fc_nxt] = b;
          fc_nxt = fc_nxt + 1'b1;
          if (fc_nxt >= hl) begin
            fc_nxt = '0;
            zero = 1'b1;
            for (int i = 0; i < 10; i++) if (4'(i) < hl && hb_nxt[i] != '0) zero = 1'b0;
            if (zero) begin
              ph_nxt = PH_DONE; emit = 1'b1; ekind = id3p_pkg::EV_TAG_END;
            end else begin
              if (hl == 4'd6) begin
                fidn = {8'h00, hb_nxt[0], hb_nxt[1], hb_nxt[2]};
                frem_nxt = {8'h00, hb_nxt[3], hb_nxt[4], hb_nxt[5]};
                ffl_nxt = '0;
              end else begin
                fidn = {hb_nxt[0], hb_nxt[1], hb_nxt[2], hb_nxt[3]};
                frem_nxt = (mv_nxt == 3'd4) ?
                  {4'h0, hb_nxt[4][6:0], hb_nxt[5][6:0], hb_nxt[6][6:0], hb_nxt[7][6:0]} :
                  {hb_nxt[4], hb_nxt[5], hb_nxt[6], hb_nxt[7]};
                ffl_nxt = {hb_nxt[8], hb_nxt[9]};
              end
              fid_nxt = fidn;
              if (mv_nxt == 3'd2) begin
                if (fidn == 32'h545031) f = 3'd0;
                else if (fidn == 32'h54414C) f = 3'd1;
                else if (fidn == 32'h545432) f = 3'd2;
                else if (fidn == 32'h54524B) f = 3'd3;
              end else begin
                if (fidn == 32'h54504531) f = 3'd0;
                else if (fidn == 32'h54414C42) f = 3'd1;
                else if (fidn == 32'h54495432) f = 3'd2;
                else if (fidn == 32'h5452434B) f = 3'd3;
              end
              hit = !f[2] && mask[f[1:0]];
              pff_nxt = 1'b0; ce_nxt = '0;
              if (hit && mv_nxt == 3'd4 && ffl_nxt[1] && !ffl_nxt[0]) begin
                cf_nxt = f[1:0];
                ph_nxt = (frem_nxt == '0) ? PH_FHDR : PH_SKIP;
                emit = 1'b1; ekind = id3p_pkg::EV_NO_DLI; efld = f[1:0];
              end else if (frem_nxt == '0) begin
                ph_nxt = PH_FHDR;
              end else if (hit) begin
                cf_nxt = f[1:0];
                ph_nxt = (mv_nxt == 3'd4 && ffl_nxt[0]) ? PH_DLI : PH_ENC;
              end else begin
                ph_nxt = PH_SKIP;
              end
            end
          end
        end
        PH_DLI: begin
          fc_nxt = fc_nxt + 1'b1;
          frem_nxt = fr_dec;
          if (frem_nxt == '0) begin ph_nxt = PH_FHDR; fc_nxt = '0; end
          else if (fc_nxt >= 4'd4) begin fc_nxt = '0; ph_nxt = PH_ENC; end
        end
        PH_ENC: begin
          frem_nxt = fr_dec;
          if (b > 8'd3) begin
            emit = 1'b1; ekind = id3p_pkg::EV_BAD_ENC; efld = cf_nxt;
            if (frem_nxt == '0) begin ph_nxt = PH_FHDR; fc_nxt = '0; end
            else ph_nxt = PH_SKIP;
          end else begin
            ce_nxt = b[1:0];
            if (frem_nxt == '0) begin ph_nxt = PH_FHDR; fc_nxt = '0; end
            else ph_nxt = PH_TEXT;
          end
        end
        PH_TEXT: begin
          last = frem_nxt <= 32'd1;
          unsync = mv_nxt == 3'd4 && ffl_nxt[1];
          frem_nxt = fr_dec;
          if (frem_nxt == '0) begin ph_nxt = PH_FHDR; fc_nxt = '0; end
          if (unsync && pff_nxt && b == 8'h00 && !last) begin
            pff_nxt = 1'b0;
          end else begin
            pff_nxt = unsync && b == 8'hFF;
            emit = 1'b1; ekind = id3p_pkg::EV_TEXT; efld = cf_nxt; eenc = ce_nxt;
            ebyte = b; elast = last;
          end
        end
        default: begin
          frem_nxt = fr_dec;
          if (frem_nxt == '0) begin ph_nxt = PH_FHDR; fc_nxt = '0; end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_HDR; mv_r <= '0; tsz_r <= '0; bc_r <= '0; fid_r <= '0; frem_r <= '0;
      ffl_r <= '0; fc_r <= '0; pff_r <= 1'b0; cf_r <= '0; ce_r <= '0; ov_r <= 1'b0;
      for (int i = 0; i < 10; i++) hb_r[i] <= '0;
    end else begin
      if (fire) begin
        ph_r <= ph_nxt; mv_r <= mv_nxt; tsz_r <= tsz_nxt; bc_r <= bc_nxt; fid_r <= fid_nxt;
        frem_r <= frem_nxt; ffl_r <= ffl_nxt; fc_r <= fc_nxt; pff_r <= pff_nxt;
        cf_r <= cf_nxt; ce_r <= ce_nxt;
        for (int i = 0; i < 10; i++) hb_r[i] <= hb_nxt[i];
      end
      if (fire && emit) begin
        ov_r <= 1'b1;
        ob_r <= '{event_kind: ekind, tag_version: mv_nxt, field_id: efld,
                  text_encoding: eenc, text_byte: ebyte, last_of_frame: elast};
      end else if (out_pop && ov_r) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule

/* hdl/id3v2_tag_frame_parser.sv */
// channel | direction | handshake              | payload
// in      | input     | in_push / in_full      | in_item_t (data_byte, start_of_file)
// out     | output    | out_empty / out_pop    | out_item_t
// cfg     | input     | cfg_valid / cfg_ready  | field_enable_mask, 4 bits
// one byte per cycle sustained while results are popped; the back-end parser handles each byte as it leaves the queue
// each byte passes the queue, then its result is registered; results sit in one output register
// the parser stalls whenever a result waits and out_pop is low; the four-entry queue then fills
// rst_n is synchronous; mask resets to all fields enabled
module id3v2_tag_frame_parser #(
  parameter int QDEPTH = id3p_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  id3p_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output id3p_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);

  logic               q_push, q_full, q_pop, q_empty;
  id3p_pkg::in_item_t q_wdata, q_rdata;
  logic [3:0]         mask_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) mask_r <= id3p_pkg::MASK_RESET;
    else if (cfg_valid) mask_r <= cfg_data;
  end

  id3p_front u_front (
    .in_push, .in_full, .in_item,
    .q_push, .q_full, .q_item(q_wdata)
  );

  id3p_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n, .wr_en(q_push), .wr_data(q_wdata), .full(q_full),
    .rd_en(q_pop), .empty(q_empty), .rd_data(q_rdata)
  );

  id3p_back u_back (
    .clk, .rst_n, .q_empty, .q_item(q_rdata), .q_pop, .mask(mask_r),
    .out_empty, .out_pop, .out_item
  );

endmodule

/* hdl/id3p_checker.sv */
module id3p_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_empty,
  input logic                out_pop,
  input id3p_pkg::out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty == 1'b0 && !out_pop |=> !out_empty && $stable(out_item))
    else $error("result changed while waiting");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.event_kind <= id3p_pkg::EV_NO_DLI)
    else $error("bad event kind");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.event_kind != id3p_pkg::EV_TEXT |-> !out_item.last_of_frame)
    else $error("last flag on non-text");

  a_ver: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.event_kind == id3p_pkg::EV_HDR_BAD |-> out_item.tag_version == 3'd0)
    else $error("version on bad header");

endmodule

bind id3v2_tag_frame_parser id3p_checker u_checker (
  .clk, .rst_n, .out_empty, .out_pop, .out_item
);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int PH_HDR = 0, PH_EXT_SIZE = 1, PH_EXT_SKIP = 2, PH_FHDR = 3, PH_DLI = 4;
  localparam int PH_ENC = 5, PH_TEXT = 6, PH_SKIP = 7, PH_DONE = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  id3p_pkg::in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  id3p_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;

  id3v2_tag_frame_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // parser state
  logic [3:0] enable_mask;
  int phase;
  logic [7:0] hbuf [10];
  logic [2:0] major;
  logic [27:0] tag_len;
  logic [27:0] consumed;
  logic [31:0] fid;
  logic [31:0] fremain;
  logic [15:0] fflags;
  int fcount;
  bit ff_seen;
  logic [1:0] fld;
  logic [1:0] enc;

  id3p_pkg::out_item_t expected_events[$];
  int errors = 0;
  int idle_counter = 0;
  bit calm = 1'b0;
  int accepted_bytes = 0;
  int quiet_cycles = 0;

  task automatic report(input string what, input id3p_pkg::out_item_t got,
                        input id3p_pkg::out_item_t want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  function automatic void parser_clear();
    phase = PH_HDR;
    for (int i = 0; i < 10; i++) hbuf[i] = '0;
    major = '0; tag_len = '0; consumed = '0; fid = '0; fremain = '0;
    fflags = '0; fcount = 0; ff_seen = 1'b0; fld = '0; enc = '0;
  endfunction

  function automatic void push_event(logic [2:0] kind, logic [1:0] f, logic [1:0] e,
                                     logic [7:0] b, bit last);
    id3p_pkg::out_item_t r;
    r.event_kind = kind; r.tag_version = major; r.field_id = f;
    r.text_encoding = e; r.text_byte = b; r.last_of_frame = last;
    expected_events.push_back(r);
  endfunction

  function automatic logic [27:0] synchsafe(int base);
    return {hbuf[base][6:0], hbuf[base+1][6:0], hbuf[base+2][6:0], hbuf[base+3][6:0]};
  endfunction

  function automatic logic [31:0] plain32(int base);
    return {hbuf[base], hbuf[base+1], hbuf[base+2], hbuf[base+3]};
  endfunction

  function automatic bit frame_done();
    if (fremain > 0) fremain--;
    if (fremain == 0) begin
      phase = PH_FHDR; fcount = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int wanted_field();
    int f;
    f = 4;
    if (major == 2) begin
      case (fid)
        32'h545031: f = 0;
        32'h54414C: f = 1;
        32'h545432: f = 2;
        32'h54524B: f = 3;
        default: f = 4;
      endcase
    end else begin
      case (fid)
        32'h54504531: f = 0;
        32'h54414C42: f = 1;
        32'h54495432: f = 2;
        32'h5452434B: f = 3;
        default: f = 4;
      endcase
    end
    if (f < 4 && !enable_mask[f]) f = 4;
    return f;
  endfunction

  function automatic void parse_byte(id3p_pkg::in_item_t it);
    logic [7:0] b;
    int hl;
    int f;
    bit ok;
    bit zero;
    bit last;
    bit unsync;
    logic [31:0] n;
    b = it.data_byte;
    hl = (major == 2) ? 6 : 10;
    if (it.start_of_file) parser_clear();
    if (phase == PH_HDR) begin
      if (fcount < 10) hbuf[fcount] = b;
      fcount++;
      if (fcount < 10) return;
      ok = hbuf[0] == 8'h49 && hbuf[1] == 8'h44 && hbuf[2] == 8'h33 && hbuf[3] != 8'hFF &&
           hbuf[4] != 8'hFF && hbuf[5][3:0] == 0 &&
           ((hbuf[6] | hbuf[7] | hbuf[8] | hbuf[9]) & 8'h80) == 0 &&
           hbuf[3] >= 2 && hbuf[3] <= 4;
      fcount = 0;
      if (!ok) begin
        major = '0; phase = PH_DONE;
        push_event(id3p_pkg::EV_HDR_BAD, 0, 0, 0, 0);
        return;
      end
      major = hbuf[3][2:0];
      tag_len = synchsafe(6);
      consumed = '0; fremain = '0;
      phase = (hbuf[5][6] && major >= 3) ? PH_EXT_SIZE : PH_FHDR;
      push_event(id3p_pkg::EV_HDR_OK, 0, 0, 0, 0);
      return;
    end
    if (phase >= PH_DONE) return;
    if (phase == PH_FHDR && fcount == 0 && 29'(consumed) + 29'(hl) >= 29'(tag_len)) begin
      phase = PH_DONE;
      push_event(id3p_pkg::EV_TAG_END, 0, 0, 0, 0);
      return;
    end
    if (consumed < id3p_pkg::COUNT_MAX) consumed++;
    case (phase)
      PH_EXT_SIZE: begin
        if (fcount < 4) hbuf[fcount] = b;
        fcount++;
        if (fcount >= 4) begin
          if (major == 4) begin
            n = 32'(synchsafe(0));
            n = (n >= 4) ? n - 4 : 0;
          end else begin
            n = plain32(0);
          end
          fremain = n;
          if (n == 0) begin
            phase = PH_FHDR; fcount = 0;
          end else begin
            phase = PH_EXT_SKIP;
          end
        end
      end
      PH_FHDR: begin
        if (fcount < 10) hbuf[fcount] = b;
        fcount++;
        if (fcount < hl) return;
        fcount = 0;
        zero = 1'b1;
        for (int i = 0; i < hl; i++) if (hbuf[i] != 0) zero = 1'b0;
        if (zero) begin
          phase = PH_DONE;
          push_event(id3p_pkg::EV_TAG_END, 0, 0, 0, 0);
          return;
        end
        if (hl == 6) begin
          fid = {8'h00, hbuf[0], hbuf[1], hbuf[2]};
          fremain = {8'h00, hbuf[3], hbuf[4], hbuf[5]};
          fflags = '0;
        end else begin
          fid = plain32(0);
          fremain = (major == 4) ? 32'(synchsafe(4)) : plain32(4);
          fflags = {hbuf[8], hbuf[9]};
        end
        f = wanted_field();
        ff_seen = 1'b0; enc = '0;
        if (f < 4 && major == 4 && fflags[1] && !fflags[0]) begin
          fld = f[1:0];
          if (fremain == 0) begin
            phase = PH_FHDR; fcount = 0;
          end else begin
            phase = PH_SKIP;
          end
          push_event(id3p_pkg::EV_NO_DLI, f[1:0], 0, 0, 0);
          return;
        end
        if (fremain == 0) begin
          phase = PH_FHDR; fcount = 0;
        end else if (f < 4) begin
          fld = f[1:0];
          phase = (major == 4 && fflags[0]) ? PH_DLI : PH_ENC;
        end else begin
          phase = PH_SKIP;
        end
      end
      PH_DLI: begin
        fcount++;
        if (!frame_done() && fcount >= 4) begin
          fcount = 0; phase = PH_ENC;
        end
      end
      PH_ENC: begin
        if (b > 3) begin
          if (!frame_done()) phase = PH_SKIP;
          push_event(id3p_pkg::EV_BAD_ENC, fld, 0, 0, 0);
          return;
        end
        enc = b[1:0];
        if (!frame_done()) phase = PH_TEXT;
      end
      PH_TEXT: begin
        last = fremain <= 1;
        unsync = major == 4 && fflags[1];
        void'(frame_done());
        if (unsync && ff_seen && b == 0 && !last) begin
          ff_seen = 1'b0;
          return;
        end
        ff_seen = unsync && b == 8'hFF;
        push_event(id3p_pkg::EV_TEXT, fld, enc, b, last);
      end
      default: void'(frame_done());
    endcase
  endfunction

  function automatic bit take_idle();
    return !calm && ($urandom_range(0, 99) < 10);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit sof);
    while (take_idle()) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= '{data_byte: b, start_of_file: sof};
    @(posedge clk);
    while (in_full) @(posedge clk);
    parse_byte('{data_byte: b, start_of_file: sof});
    @(negedge clk);
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$], input bit first_sof);
    foreach (bytes[i]) send_byte(bytes[i], first_sof && i == 0);
  endtask

  task automatic wait_quiet();
    in_push <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mask(input logic [3:0] m);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    enable_mask = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // builders for tag images
  function automatic void add_header(ref logic [7:0] q[$], input logic [7:0] ver,
                                     input logic [7:0] flags, input int size);
    q.push_back(8'h49); q.push_back(8'h44); q.push_back(8'h33);
    q.push_back(ver); q.push_back(8'h00); q.push_back(flags);
    q.push_back(8'((size >> 21) & 'h7F)); q.push_back(8'((size >> 14) & 'h7F));
    q.push_back(8'((size >> 7) & 'h7F)); q.push_back(8'(size & 'h7F));
  endfunction

  function automatic void add_frame(ref logic [7:0] q[$], input int ver, input int which,
                                    input logic [15:0] flags, input logic [7:0] body[$]);
    logic [31:0] id;
    int n;
    n = body.size();
    case (which)
      0: id = (ver == 2) ? 32'h545031 : 32'h54504531;
      1: id = (ver == 2) ? 32'h54414C : 32'h54414C42;
      2: id = (ver == 2) ? 32'h545432 : 32'h54495432;
      3: id = (ver == 2) ? 32'h54524B : 32'h5452434B;
      default: id = (ver == 2) ? 32'h434F4D : 32'h434F4D4D;
    endcase
    if (ver == 2) begin
      q.push_back(id[23:16]); q.push_back(id[15:8]); q.push_back(id[7:0]);
      q.push_back(8'(n >> 16)); q.push_back(8'(n >> 8)); q.push_back(8'(n));
    end else begin
      q.push_back(id[31:24]); q.push_back(id[23:16]); q.push_back(id[15:8]);
      q.push_back(id[7:0]);
      if (ver == 4) begin
        q.push_back(8'((n >> 21) & 'h7F)); q.push_back(8'((n >> 14) & 'h7F));
        q.push_back(8'((n >> 7) & 'h7F)); q.push_back(8'(n & 'h7F));
      end else begin
        q.push_back(8'(n >> 24)); q.push_back(8'(n >> 16)); q.push_back(8'(n >> 8));
        q.push_back(8'(n));
      end
      q.push_back(flags[15:8]); q.push_back(flags[7:0]);
    end
    foreach (body[i]) q.push_back(body[i]);
  endfunction

  function automatic void random_body(ref logic [7:0] body[$], input int ver,
                                      input logic [15:0] flags);
    int n;
    body.delete();
    if (ver == 4 && flags[0]) repeat (4) body.push_back(8'($urandom_range(0, 255)));
    body.push_back(8'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 255)
                                                   : $urandom_range(0, 3)));
    n = $urandom_range(0, 8);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: body.push_back(8'hFF);
        1: body.push_back(8'h00);
        default: body.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  task automatic test_directed();
    logic [7:0] q[$];
    logic [7:0] body[$];
    // v2.3 with extended header and all four fields, then padding
    add_header(q, 3, 8'h40, 80);
    q.push_back(0); q.push_back(0); q.push_back(0); q.push_back(2);
    q.push_back(8'hAA); q.push_back(8'h55);
    body = '{8'h00, 8'h41, 8'hFF};
    add_frame(q, 3, 0, 0, body);
    body = '{8'h03};
    add_frame(q, 3, 1, 0, body);
    body.delete();
    add_frame(q, 3, 2, 0, body);
    body = '{8'h07, 8'h01};
    add_frame(q, 3, 3, 0, body);
    repeat (10) q.push_back(0);
    send_bytes(q, 1);
    // v2.4 unsync with length indicator, and unsync without one
    q.delete();
    add_header(q, 4, 8'h40, 60);
    q.push_back(0); q.push_back(0); q.push_back(0); q.push_back(6);
    q.push_back(1); q.push_back(2);
    body = '{8'h00, 8'h00, 8'h00, 8'h04, 8'h01, 8'hFF, 8'h00, 8'hFF, 8'h00};
    add_frame(q, 4, 2, 16'h0003, body);
    body = '{8'h01, 8'h02};
    add_frame(q, 4, 0, 16'h0002, body);
    send_bytes(q, 1);
    // v2.2 frames and a bad encoding, then tag end by size
    q.delete();
    add_header(q, 2, 8'h40, 22);
    body = '{8'h09, 8'h10};
    add_frame(q, 2, 0, 0, body);
    body = '{8'h01, 8'hFF, 8'h80};
    add_frame(q, 2, 2, 0, body);
    q.push_back(8'h12);
    send_bytes(q, 1);
    // bad headers: magic, version, flags, size bit, unsupported major
    q.delete();
    add_header(q, 3, 8'h0F, 100);
    send_bytes(q, 1);
    q.delete();
    add_header(q, 5, 8'h00, 100);
    send_bytes(q, 1);
    q = '{8'hFF, 8'h44, 8'h33, 8'hFF, 8'hFF, 8'hF0, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01};
    send_bytes(q, 1);
  endtask

  task automatic random_tag();
    logic [7:0] q[$];
    logic [7:0] body[$];
    int ver;
    int frames;
    logic [15:0] flags;
    int which;
    int total;
    ver = $urandom_range(2, 4);
    frames = $urandom_range(1, 5);
    for (int k = 0; k < frames; k++) begin
      which = $urandom_range(0, 4);
      flags = '0;
      if (ver == 4) flags = {8'($urandom_range(0, 255)), 6'b0, 2'($urandom_range(0, 3))};
      if (ver == 3) flags = 16'($urandom_range(0, 65535));
      random_body(body, ver, flags);
      add_frame(q, ver, which, flags, body);
    end
    if ($urandom_range(0, 1)) repeat (ver == 2 ? 6 : 10) q.push_back(0);
    total = q.size() + $urandom_range(0, 12) - 6;
    if (total < 0) total = 0;
    body = q;
    q.delete();
    add_header(q, 8'(ver), ($urandom_range(0, 3) == 0) ? 8'h40 : 8'h00, total);
    if (q[5][6] && ver >= 3) begin
      q.push_back(0); q.push_back(0); q.push_back(0); q.push_back(8'(ver == 4 ? 5 : 1));
      q.push_back(8'($urandom_range(0, 255)));
    end
    foreach (body[i]) q.push_back(body[i]);
    if ($urandom_range(0, 19) == 0) q[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
    send_bytes(q, 1);
    for (int i = 0; i < 3; i++) if ($urandom_range(0, 3) == 0)
      send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic test_random(input int budget);
    int sent_before;
    sent_before = accepted_bytes;
    while (accepted_bytes - sent_before < budget) random_tag();
  endtask

  task automatic test_config();
    logic [3:0] masks[4];
    masks = '{4'h0, 4'h5, 4'hA, 4'hF};
    foreach (masks[i]) begin
      write_mask(masks[i]);
      test_random(60);
    end
  endtask

  always @(posedge clk) begin
    if (in_push && !in_full) accepted_bytes <= accepted_bytes + 1;
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("id3v2_tag_frame_parser regression: fail");
      $finish;
    end
    if (rst_n && out_pop && !out_empty) begin
      if (expected_events.size() == 0) begin
        report("unexpected transaction", out_item, '0);
      end else begin
        id3p_pkg::out_item_t want;
        want = expected_events.pop_front();
        if (out_item.event_kind != want.event_kind) report("event_kind", out_item, want);
        else if (out_item.tag_version != want.tag_version) report("tag_version", out_item, want);
        else if (out_item.field_id != want.field_id) report("field_id", out_item, want);
        else if (out_item.text_encoding != want.text_encoding)
          report("text_encoding", out_item, want);
        else if (out_item.text_byte != want.text_byte) report("text_byte", out_item, want);
        else if (out_item.last_of_frame != want.last_of_frame)
          report("last_of_frame", out_item, want);
      end
    end
  end

  always @(negedge clk) begin
    idle_counter <= idle_counter + 1;
    calm <= (idle_counter % 3000) > 2400;
    out_pop <= rst_n && !take_idle();
  end

  initial begin
    parser_clear();
    enable_mask = id3p_pkg::MASK_RESET;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    write_mask(4'h3);
    test_directed();
    test_config();
    test_random(200);
    wait_quiet();
    if (errors == 0) begin
      $display("id3v2_tag_frame_parser regression: pass");
    end else begin
      $display("id3v2_tag_frame_parser regression: fail");
    end
    $finish;
  end

endmodule
